[hw/rtl/escape_sequence_decoder_top_macros.svh]
// Assertion macros for the escape sequence decoder.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ESD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("escape decoder check failed");

// Next-cycle implication, disabled during reset.
`define ESD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("escape decoder check failed");

`endif

[hw/rtl/esd_pkg.sv]
// Shared types, constants and character helpers for the escape sequence decoder.
// No dependencies.
package esd_pkg;

    localparam int unsigned BUF_DEPTH = 6;

    localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
    localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2    = 8'hc0;
    localparam logic [7:0]  UTF8_LEAD3    = 8'he0;
    localparam logic [7:0]  UTF8_CONT     = 8'h80;
    localparam logic [7:0]  CHR_ESC       = 8'h1b;
    localparam logic [7:0]  CHR_BEL       = 8'h07;
    localparam logic [7:0]  CHR_BACKSLASH = 8'h5c;
    localparam logic [7:0]  CHR_X         = 8'h78;
    localparam logic [7:0]  CHR_U         = 8'h75;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        K_PLAIN,
        K_CHAR,
        K_OCT,
        K_HEX,
        K_U16
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;     // append the accepted input byte to the window
        logic       emit;     // load one decoded byte into the output register
        logic       advance;  // drop the head item from the window
        logic       last;     // mark the emitted byte as the final one
        logic [1:0] idx;      // which byte of the head item to emit
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] fill;      // bytes held in the window
        logic [1:0] cnt;       // bytes produced by the head item, 1 to 3
        logic       rem_zero;  // head item consumes everything held
        logic       out_free;  // output register can take a byte this cycle
    } t_sts;

    function automatic logic is_oct(input t_byte c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input t_byte c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input t_byte c);
        logic [3:0] v;
        v = 4'h0;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c[3:0];
        end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic t_byte named_ctrl(input t_byte c);
        t_byte r;
        unique case (c)
            8'h30:   r = 8'h00;       // '0'
            8'h61:   r = CHR_BEL;     // 'a'
            8'h62:   r = 8'h08;       // 'b'
            8'h65:   r = CHR_ESC;     // 'e'
            8'h66:   r = 8'h0c;       // 'f'
            8'h6e:   r = 8'h0a;       // 'n'
            8'h72:   r = 8'h0d;       // 'r'
            8'h74:   r = 8'h09;       // 't'
            8'h76:   r = 8'h0b;       // 'v'
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/esd_ctrl.sv]
// Controller state machine of the escape sequence decoder.
// Depends on esd_pkg; drives commands to esd_datapath and reads its status.
module esd_ctrl
    import esd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    input  t_sts i_sts,
    output logic o_in_stall,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state     r_state, n_state;
    logic       r_flush, n_flush;
    logic [1:0] r_idx, n_idx;
    logic       in_acc;
    logic       item_done;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign item_done  = (r_idx == (i_sts.cnt - 2'd1));

    always_comb begin
        n_state      = r_state;
        n_flush      = r_flush;
        n_idx        = r_idx;
        o_cmd        = '0;
        o_cmd.idx    = r_idx;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = in_acc;
                if (in_acc) begin
                    n_flush = i_in_last;
                    n_idx   = 2'd0;
                    // The new byte completes a six-byte window, or ends the string.
                    if (i_in_last || (i_sts.fill == 3'd5)) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = r_flush && i_sts.rem_zero && item_done;
                    if (item_done) begin
                        o_cmd.advance = 1'b1;
                        n_idx         = 2'd0;
                        if (!r_flush || i_sts.rem_zero) begin
                            n_state = S_IDLE;
                            n_flush = 1'b0;
                        end
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
            r_idx   <= n_idx;
        end
    end

endmodule

[hw/rtl/esd_datapath.sv]
// Datapath of the escape sequence decoder: lookahead window, head decode, output register.
// Depends on esd_pkg; controlled by esd_ctrl.
module esd_datapath
    import esd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_byte i_in_byte,
    input  logic  i_out_stall,
    output t_sts  o_sts,
    output logic  o_out_valid,
    output t_byte o_out_byte,
    output logic  o_out_last
);

    t_byte      r_buf [BUF_DEPTH];
    logic [2:0] r_fill;
    logic       r_out_valid;
    t_byte      r_out_byte;
    logic       r_out_last;

    t_kind      kind;
    logic [15:0] cp;
    t_byte      b0, b1, b2, sel_byte;
    logic [1:0] cnt;
    logic [2:0] cons;

    // Classify the item at the head of the window, given r_fill bytes held.
    always_comb begin
        priority if ((r_fill < 3'd2) || (r_buf[0] != CHR_BACKSLASH)) begin
            kind = K_PLAIN;
        end else if (r_fill < 3'd4) begin
            kind = K_CHAR;
        end else if (is_oct(r_buf[1]) && is_oct(r_buf[2]) && is_oct(r_buf[3])) begin
            kind = K_OCT;
        end else if ((r_buf[1] == CHR_X) && is_hex(r_buf[2]) && is_hex(r_buf[3])) begin
            kind = K_HEX;
        end else if (r_fill < 3'd6) begin
            kind = K_CHAR;
        end else if ((r_buf[1] == CHR_U) && is_hex(r_buf[2]) && is_hex(r_buf[3]) &&
                     is_hex(r_buf[4]) && is_hex(r_buf[5])) begin
            kind = K_U16;
        end else begin
            kind = K_CHAR;
        end
    end

    assign cp = {hex_val(r_buf[2]), hex_val(r_buf[3]), hex_val(r_buf[4]), hex_val(r_buf[5])};

    always_comb begin
        b0   = r_buf[0];
        b1   = '0;
        b2   = '0;
        cnt  = 2'd1;
        cons = 3'd1;
        unique case (kind)
            K_U16: begin
                cons = 3'd6;
                if (cp < CP_TWO_BYTE) begin
                    b0 = cp[7:0];
                end else if (cp < CP_THREE_BYTE) begin
                    cnt = 2'd2;
                    b0  = UTF8_LEAD2 | {3'b000, cp[10:6]};
                    b1  = UTF8_CONT | {2'b00, cp[5:0]};
                end else begin
                    cnt = 2'd3;
                    b0  = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                    b1  = UTF8_CONT | {2'b00, cp[11:6]};
                    b2  = UTF8_CONT | {2'b00, cp[5:0]};
                end
            end
            K_HEX: begin
                cons = 3'd4;
                b0   = {hex_val(r_buf[2]), hex_val(r_buf[3])};
            end
            K_OCT: begin
                // Three octal digits make nine bits; the top one is dropped.
                cons = 3'd4;
                b0   = {r_buf[1][1:0], r_buf[2][2:0], r_buf[3][2:0]};
            end
            K_CHAR: begin
                cons = 3'd2;
                b0   = named_ctrl(r_buf[1]);
            end
            default: begin
                cons = 3'd1;
                b0   = r_buf[0];
            end
        endcase
    end

    always_comb begin
        unique case (i_cmd.idx)
            2'd0:    sel_byte = b0;
            2'd1:    sel_byte = b1;
            default: sel_byte = b2;
        endcase
    end

    assign o_sts.fill     = r_fill;
    assign o_sts.cnt      = cnt;
    assign o_sts.rem_zero = (r_fill == cons);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // Window storage: append at the fill point, or drop the consumed head item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 3'd0;
        end else if (i_cmd.load) begin
            r_fill <= r_fill + 3'd1;
        end else if (i_cmd.advance) begin
            r_fill <= r_fill - cons;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_buf[r_fill] <= i_in_byte;
        end else if (i_cmd.advance) begin
            for (int i = 0; i < BUF_DEPTH; i++) begin
                if ((i + int'(cons)) < BUF_DEPTH) begin
                    r_buf[i] <= r_buf[i + int'(cons)];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= sel_byte;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

[hw/rtl/escape_sequence_decoder_top.sv]
// Top level of the backslash escape decoder with UTF-8 output for \uHHHH.
// Depends on esd_pkg, esd_ctrl, esd_datapath and escape_sequence_decoder_top_macros.svh.
//
//   channel | direction | signals                                  | meaning
//   in      | input     | i_in_valid, o_in_stall, i_in_byte/_last  | raw string bytes
//   out     | output    | o_out_valid, i_out_stall, o_out_byte/_last | decoded bytes
//
// A byte that decodes nothing is taken in the idle state. A byte that completes a
// six-byte window moves to the emit state, where the output register takes the
// head item's decoded bytes (1 to 3) one per cycle unless the output stalls. The
// final byte of a string flushes the whole window, up to 6 decoded bytes.
// Reset is synchronous and active low and empties the window; there is no
// clearing pass. A stall on the output holds the decoder in its emit state.
`include "escape_sequence_decoder_top_macros.svh"

module escape_sequence_decoder_top
    import esd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    // Command and status between the controller and the datapath.
    t_cmd cmd;
    t_sts sts;
    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // The controller accepts a transaction only in its idle state, then steps through
    // the head item's decoded bytes (every item on a flush), one per unstalled cycle.
    esd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_last),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the window, decodes its head combinationally and
    // registers each output transaction.
    esd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_byte   (i_in_byte),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

    // The window never overflows, and is below six bytes whenever input is open.
    `ESD_ASSERT_NOW(a_fill_bound, !o_in_stall, sts.fill <= 3'd5)
    // A final input byte always leads to a flush before new input is taken.
    `ESD_ASSERT_NEXT(a_last_flushes, in_acc && i_in_last, o_in_stall)
    // Bytes are only emitted from a non-empty window.
    `ESD_ASSERT_NOW(a_emit_nonempty, cmd.emit, sts.fill != 3'd0)

endmodule
